>>> hdl/lifeb_pkg.sv
package lifeb_pkg;

    // Default board dimension (rows and columns of storage)
    localparam int MAX_GRID_DEF = 64;

    // Register defaults and widths
    localparam int            GRID_W     = 7;
    localparam logic [6:0]    GRID_RESET = 7'd64;

    // Word index of the grid_size register on the config port
    localparam logic          REG_GRID_SIZE = 1'b0;

    // Item opcodes
    typedef enum logic [1:0] {
        MODE_PRESS   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_STEP    = 2'd2,
        MODE_READ    = 2'd3
    } t_mode;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // Row-level control for the rule unit
    typedef struct packed {
        logic row_on;   // current row lies inside the active square
        logic nxt_on;   // row below lies inside the active square
    } t_rule_ctl;

    // B3/S23 rule on eight neighbor bits
    function automatic logic life_next(input logic [7:0] nb, input logic alive);
        logic [3:0] cnt;
        cnt = '0;
        for (int k = 0; k < 8; k++) begin
            cnt = cnt + {3'b000, nb[k]};
        end
        return (cnt == 4'd3) || (alive && (cnt == 4'd2));
    endfunction

endpackage

>>> hdl/lifeb_row_cell.sv
// One board row; shifts toward the head of the ring when enabled
module lifeb_row_cell #(
    parameter int WIDTH = lifeb_pkg::MAX_GRID_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [WIDTH-1:0] i_row_in,
    output logic [WIDTH-1:0] o_row
);

    logic [WIDTH-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_shift) begin
            r_row <= i_row_in;
        end
    end

    assign o_row = r_row;

endmodule

>>> hdl/lifeb_row_rule.sv
// Next generation of one row from a three-row window
module lifeb_row_rule #(
    parameter int WIDTH = lifeb_pkg::MAX_GRID_DEF
) (
    input  logic [WIDTH-1:0]   i_prev,
    input  logic [WIDTH-1:0]   i_cur,
    input  logic [WIDTH-1:0]   i_nxt,
    input  logic [WIDTH-1:0]   i_col_on,
    input  lifeb_pkg::t_rule_ctl i_ctl,
    output logic [WIDTH-1:0]   o_next
);

    // Dead padding on both sides; columns outside the square count as dead
    logic [WIDTH+1:0] w_pe;
    logic [WIDTH+1:0] w_me;
    logic [WIDTH+1:0] w_de;

    assign w_pe = {1'b0, i_prev & i_col_on, 1'b0};
    assign w_me = {1'b0, i_cur & i_col_on, 1'b0};
    assign w_de = {1'b0, i_nxt & i_col_on & {WIDTH{i_ctl.nxt_on}}, 1'b0};

    for (genvar c = 0; c < WIDTH; c++) begin : g_col
        logic [7:0] w_nb;
        assign w_nb = {w_pe[c], w_pe[c+1], w_pe[c+2],
                       w_me[c],            w_me[c+2],
                       w_de[c], w_de[c+1], w_de[c+2]};
        // cells outside the square keep their value
        assign o_next[c] = (i_ctl.row_on && i_col_on[c]) ?
                           lifeb_pkg::life_next(w_nb, i_cur[c]) : i_cur[c];
    end

endmodule

>>> hdl/life_automaton_board.sv
// Step, and press or read inside the grid, sweep one full revolution of the row ring
// in ST_SWEEP before ST_DONE loads the output register; release and out-of-grid press
// or read go straight to ST_DONE. The input stalls from accept until the result is loaded
// (held while the output is stalled); the ring moves one row per cycle past the rule unit.
// Reset (synchronous, active low) clears every cell, the click lock and sets
// grid_size to 64; no clearing pass is needed.
module life_automaton_board #(
    parameter int MAX_GRID = lifeb_pkg::MAX_GRID_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_cell_value,
    output logic        o_accepted,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_GRID);
    localparam int SW = (CW + 1 > lifeb_pkg::GRID_W) ? CW + 1 : lifeb_pkg::GRID_W;
    localparam logic [CW-1:0] T_LAST = CW'(MAX_GRID - 1);

    lifeb_pkg::t_state r_state, n_state;

    logic [6:0]          r_grid_size;
    logic                r_lock;
    logic [CW-1:0]       r_t;
    logic [MAX_GRID-1:0] r_prev;
    lifeb_pkg::t_mode    r_mode;
    logic [5:0]          r_row;
    logic [5:0]          r_col;
    logic                r_tog;
    logic                r_acc;
    logic                r_val;
    logic                r_ov;
    logic                r_o_val;
    logic                r_o_acc;

    logic                w_in_acc;
    logic                w_shift;
    logic                w_load;
    logic [SW-1:0]       w_n;
    logic                w_inside;
    logic                w_need_sweep;
    logic                w_acc0;
    logic                w_tog0;
    logic                w_hit;
    logic                w_cfg_wr;
    logic [MAX_GRID-1:0] w_col_on;
    logic [MAX_GRID-1:0] w_colsel;
    logic [MAX_GRID-1:0] w_rule_out;
    logic [MAX_GRID-1:0] w_feed;
    logic [MAX_GRID-1:0] w_rows [MAX_GRID];
    lifeb_pkg::t_rule_ctl w_ctl;

    // Config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == lifeb_pkg::REG_GRID_SIZE);
    assign prdata   = (paddr[2] == lifeb_pkg::REG_GRID_SIZE) ?
                      {25'd0, r_grid_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= lifeb_pkg::GRID_RESET;
        end else if (w_cfg_wr) begin
            r_grid_size <= pwdata[6:0];
        end
    end

    // Active size: zero means 1, clamp to storage
    always_comb begin
        if (r_grid_size == 7'd0) begin
            w_n = SW'(1);
        end else if (SW'(r_grid_size) > SW'(MAX_GRID)) begin
            w_n = SW'(MAX_GRID);
        end else begin
            w_n = SW'(r_grid_size);
        end
    end

    // Per-column masks
    for (genvar c = 0; c < MAX_GRID; c++) begin : g_mask
        assign w_col_on[c] = SW'(c) < w_n;
        assign w_colsel[c] = SW'(r_col) == SW'(c);
    end

    // Item decode at accept
    assign w_in_acc = i_valid && !o_stall;
    assign w_inside = (SW'(i_row) < w_n) && (SW'(i_col) < w_n);

    always_comb begin
        w_need_sweep = 1'b0;
        w_acc0       = 1'b0;
        w_tog0       = 1'b0;
        case (lifeb_pkg::t_mode'(i_mode))
            lifeb_pkg::MODE_PRESS: begin
                w_need_sweep = w_inside;
                w_acc0       = w_inside && !r_lock;
                w_tog0       = w_inside && !r_lock;
            end
            lifeb_pkg::MODE_RELEASE: begin
                w_acc0 = 1'b1;
            end
            lifeb_pkg::MODE_STEP: begin
                w_need_sweep = 1'b1;
                w_acc0       = 1'b1;
            end
            lifeb_pkg::MODE_READ: begin
                w_need_sweep = w_inside;
                w_acc0       = w_inside;
            end
            default: begin
                w_need_sweep = 1'b0;
            end
        endcase
    end

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lifeb_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_need_sweep ? lifeb_pkg::ST_SWEEP : lifeb_pkg::ST_DONE;
                end
            end
            lifeb_pkg::ST_SWEEP: begin
                if (r_t == T_LAST) begin
                    n_state = lifeb_pkg::ST_DONE;
                end
            end
            lifeb_pkg::ST_DONE: begin
                if (w_load) begin
                    n_state = lifeb_pkg::ST_IDLE;
                end
            end
            default: n_state = lifeb_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        o_stall = 1'b1;
        w_shift = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            lifeb_pkg::ST_IDLE:  o_stall = 1'b0;
            lifeb_pkg::ST_SWEEP: w_shift = 1'b1;
            lifeb_pkg::ST_DONE:  w_load  = !r_ov || !i_stall;
            default:             o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lifeb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Click lock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock <= 1'b0;
        end else if (w_in_acc) begin
            if (lifeb_pkg::t_mode'(i_mode) == lifeb_pkg::MODE_RELEASE) begin
                r_lock <= 1'b0;
            end else if (w_tog0) begin
                r_lock <= 1'b1;
            end
        end
    end

    // Ring head: row r_t sits in cell 0 during the sweep
    assign w_hit = SW'(r_t) == SW'(r_row);

    assign w_ctl.row_on = SW'(r_t) < w_n;
    assign w_ctl.nxt_on = (SW'(r_t) + SW'(1)) < w_n;

    lifeb_row_rule #(
        .WIDTH (MAX_GRID)
    ) u_rule (
        .i_prev   (r_prev),
        .i_cur    (w_rows[0]),
        .i_nxt    (w_rows[1]),
        .i_col_on (w_col_on),
        .i_ctl    (w_ctl),
        .o_next   (w_rule_out)
    );

    // Row written back at the tail of the ring
    always_comb begin
        if (r_mode == lifeb_pkg::MODE_STEP) begin
            w_feed = w_rule_out;
        end else if (w_hit && r_tog) begin
            w_feed = w_rows[0] ^ w_colsel;
        end else begin
            w_feed = w_rows[0];
        end
    end

    // Ring of row cells
    for (genvar i = 0; i < MAX_GRID; i++) begin : g_ring
        logic [MAX_GRID-1:0] w_in;
        if (i == MAX_GRID - 1) begin : g_tail
            assign w_in = w_feed;
        end else begin : g_mid
            assign w_in = w_rows[i+1];
        end
        lifeb_row_cell #(
            .WIDTH (MAX_GRID)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_shift),
            .i_row_in (w_in),
            .o_row    (w_rows[i])
        );
    end

    // Sweep counter and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t <= '0;
        end else if (w_in_acc) begin
            r_t <= '0;
        end else if (w_shift) begin
            r_t <= r_t + CW'(1);
        end
    end

    // Item payload (no reset needed)
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode <= lifeb_pkg::t_mode'(i_mode);
            r_row  <= i_row;
            r_col  <= i_col;
            r_tog  <= w_tog0;
            r_acc  <= w_acc0;
            r_val  <= 1'b0;
            r_prev <= '0;
        end else if (w_shift) begin
            r_prev <= w_rows[0];
            if (w_hit && (r_mode != lifeb_pkg::MODE_STEP)) begin
                r_val <= (|(w_rows[0] & w_colsel)) ^ r_tog;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_val <= r_val;
            r_o_acc <= r_acc;
        end
    end

    assign o_valid      = r_ov;
    assign o_cell_value = r_o_val;
    assign o_accepted   = r_o_acc;

endmodule

>>> hdl/lifeb_checker.sv
// Port-level checks for the life board
module lifeb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_mode,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_cell_value,
    input logic        o_accepted,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // An accepted item stalls the input in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after item accept");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cell_value) && $stable(o_accepted))
        else $error("result changed while stalled");

    // Release with a free output gives an accepted, zero-valued result via ST_DONE and the output register
    a_release_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid &&
        (i_mode == lifeb_pkg::MODE_RELEASE) |=> ##1 (o_valid && o_accepted && !o_cell_value))
        else $error("release result missing or wrong");

    // Register write reads back
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == lifeb_pkg::REG_GRID_SIZE) |=>
        (paddr[2] != lifeb_pkg::REG_GRID_SIZE) || (prdata[6:0] == $past(pwdata[6:0])))
        else $error("grid_size readback mismatch");

endmodule

bind life_automaton_board lifeb_checker u_lifeb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_mode       (i_mode),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_cell_value (o_cell_value),
    .o_accepted   (o_accepted),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

>>> verif/life_automaton_board_test.sv
module life_automaton_board_test;

    localparam int GRID_CELLS = lifeb_pkg::MAX_GRID_DEF;
    localparam int RAND_PHASES = 11;
    localparam int RAND_PHASE_ITEMS = 114;
    localparam int RAND_TOTAL = RAND_PHASES * RAND_PHASE_ITEMS;
    // longest sweep plus margin
    localparam int SETTLE_CYCLES = GRID_CELLS + 12;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [2:0] GRID_SIZE_ADDR = 3'(4 * int'(lifeb_pkg::REG_GRID_SIZE));

    // result of one item, cell state in the upper bit
    typedef struct packed {
        logic cell_value;
        logic accepted;
    } t_life_result;

    typedef enum bit {
        DIR_ITEM,
        DIR_CFG
    } t_dir_kind;

    // one row of the directed stimulus
    typedef struct {
        t_dir_kind        kind;
        lifeb_pkg::t_mode mode;
        logic [5:0]       row;
        logic [5:0]       col;
        logic [6:0]       size;
        bit               checked;
        t_life_result     want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode = '0;
    logic [5:0]  i_row = '0;
    logic [5:0]  i_col = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_cell_value;
    logic        o_accepted;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the board, lock and grid register
    bit [GRID_CELLS-1:0] shadow_board [GRID_CELLS];
    bit                  shadow_lock = 1'b0;
    logic [6:0]          shadow_grid = lifeb_pkg::GRID_RESET;

    t_life_result pending_results [$];
    int mismatches = 0;
    int cycle_count = 0;
    int snd_idle_pct = 7;
    int rcv_stall_pct = 60;

    t_dir_row dir_tbl [29];
    logic [6:0] phase_sizes [RAND_PHASES] = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd0, 7'd127,
                                              7'd10, 7'd64, 7'd5, 7'd100, 7'd33};

    life_automaton_board dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_row        (i_row),
        .i_col        (i_col),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_value (o_cell_value),
        .o_accepted   (o_accepted),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // effective board size, grid register clamped to 1..MAX
    function automatic int grid_span();
        if (shadow_grid == 0) return 1;
        if (shadow_grid > GRID_CELLS) return GRID_CELLS;
        return int'(shadow_grid);
    endfunction

    // B3/S23 on the active square, dead cells beyond its border
    function automatic void advance_generation();
        bit [GRID_CELLS-1:0] nxt [GRID_CELLS];
        int n;
        int cnt;
        n = grid_span();
        nxt = shadow_board;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                cnt = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < n &&
                            c + dc >= 0 && c + dc < n) begin
                            cnt += shadow_board[r + dr][c + dc];
                        end
                    end
                end
                nxt[r][c] = (cnt == 3) || (shadow_board[r][c] && cnt == 2);
            end
        end
        shadow_board = nxt;
    endfunction

    // apply one item to the shadow state and return its result
    function automatic t_life_result apply_item(lifeb_pkg::t_mode mode, logic [5:0] row,
                                                logic [5:0] col);
        t_life_result res;
        bit in_grid;
        int n;
        n = grid_span();
        in_grid = (row < n) && (col < n);
        res = '0;
        case (mode)
            lifeb_pkg::MODE_PRESS: begin
                if (in_grid) begin
                    if (!shadow_lock) begin
                        shadow_board[row][col] ^= 1'b1;
                        shadow_lock = 1'b1;
                        res.accepted = 1'b1;
                    end
                    res.cell_value = shadow_board[row][col];
                end
            end
            lifeb_pkg::MODE_RELEASE: begin
                shadow_lock = 1'b0;
                res.accepted = 1'b1;
            end
            lifeb_pkg::MODE_STEP: begin
                advance_generation();
                res.accepted = 1'b1;
            end
            default: begin
                if (in_grid) begin
                    res.cell_value = shadow_board[row][col];
                    res.accepted = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    function automatic void log_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
        end
    endfunction

    // present one item, hold it until taken, then queue its result
    task automatic send_item(lifeb_pkg::t_mode mode, logic [5:0] row, logic [5:0] col,
                             bit checked = 1'b0, t_life_result want = '0);
        t_life_result res;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_row <= row;
        i_col <= col;
        do @(posedge i_clk); while (o_stall);
        res = apply_item(mode, row, col);
        pending_results = {pending_results, (checked ? want : res)};
    endtask

    // wait until the block is idle
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write grid_size, then read it back
    task automatic set_grid_size(logic [6:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= GRID_SIZE_ADDR;
        pwdata <= {25'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_grid = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {25'b0, value}) log_mismatch("grid_size readback", {25'b0, value}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // one random item or short sequence, mostly press/release pairs
    task automatic random_sequence();
        int n;
        int pick;
        logic [5:0] r;
        logic [5:0] c;
        logic [5:0] tmp;
        n = grid_span();
        pick = $urandom_range(99);
        r = 6'($urandom_range(n - 1));
        c = 6'($urandom_range(n - 1));
        if (pick < 45) begin
            send_item(lifeb_pkg::MODE_PRESS, r, c);
            send_item(lifeb_pkg::MODE_RELEASE, 6'($urandom), 6'($urandom));
        end else if (pick < 60) begin
            send_item(lifeb_pkg::MODE_STEP, 6'($urandom), 6'($urandom));
        end else if (pick < 80) begin
            send_item(lifeb_pkg::MODE_READ, r, c);
        end else if (pick < 90) begin
            // off-grid press or read
            r = 6'($urandom);
            c = 6'($urandom);
            if (n < GRID_CELLS) begin
                r = 6'($urandom_range(GRID_CELLS - 1, n));
                if ($urandom_range(1)) begin
                    tmp = r;
                    r = c;
                    c = tmp;
                end
            end
            send_item($urandom_range(1) ? lifeb_pkg::MODE_PRESS : lifeb_pkg::MODE_READ, r, c);
        end else begin
            send_item(lifeb_pkg::t_mode'($urandom_range(3)), 6'($urandom), 6'($urandom));
        end
    endtask

    // result checker and receiver back-pressure
    always @(posedge i_clk) begin : rcv_check
        t_life_result want;
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                log_mismatch("unexpected result", '0, {30'b0, o_cell_value, o_accepted});
            end else begin
                want = pending_results.pop_front();
                if (o_cell_value !== want.cell_value || o_accepted !== want.accepted) begin
                    log_mismatch("cell_value/accepted", {30'b0, want},
                                 {30'b0, o_cell_value, o_accepted});
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int done;
        int idle_phase;
        // want field: {cell_value, accepted}
        dir_tbl = '{
            '{DIR_ITEM, lifeb_pkg::MODE_READ,    6'd0,  6'd0,  7'd0,   1'b1, 2'b01},
            '{DIR_ITEM, lifeb_pkg::MODE_READ,    6'd63, 6'd63, 7'd0,   1'b1, 2'b01},
            '{DIR_ITEM, lifeb_pkg::MODE_PRESS,   6'd0,  6'd0,  7'd0,   1'b1, 2'b11},
            // press while locked
            '{DIR_ITEM, lifeb_pkg::MODE_PRESS,   6'd5,  6'd5,  7'd0,   1'b1, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_RELEASE, 6'd17, 6'd42, 7'd0,   1'b1, 2'b01},
            '{DIR_ITEM, lifeb_pkg::MODE_PRESS,   6'd63, 6'd63, 7'd0,   1'b1, 2'b11},
            '{DIR_ITEM, lifeb_pkg::MODE_RELEASE, 6'd0,  6'd0,  7'd0,   1'b1, 2'b01},
            '{DIR_ITEM, lifeb_pkg::MODE_PRESS,   6'd0,  6'd1,  7'd0,   1'b0, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_RELEASE, 6'd63, 6'd63, 7'd0,   1'b0, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_PRESS,   6'd1,  6'd0,  7'd0,   1'b0, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_RELEASE, 6'd0,  6'd0,  7'd0,   1'b0, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_STEP,    6'd42, 6'd21, 7'd0,   1'b1, 2'b01},
            '{DIR_ITEM, lifeb_pkg::MODE_READ,    6'd1,  6'd1,  7'd0,   1'b0, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_READ,    6'd63, 6'd63, 7'd0,   1'b0, 2'b00},
            // small board, off-grid items rejected
            '{DIR_CFG,  lifeb_pkg::MODE_READ,    6'd0,  6'd0,  7'd3,   1'b0, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_PRESS,   6'd3,  6'd0,  7'd0,   1'b1, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_READ,    6'd0,  6'd3,  7'd0,   1'b1, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_READ,    6'd63, 6'd63, 7'd0,   1'b1, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_PRESS,   6'd2,  6'd2,  7'd0,   1'b0, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_RELEASE, 6'd0,  6'd0,  7'd0,   1'b0, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_STEP,    6'd0,  6'd0,  7'd0,   1'b1, 2'b01},
            '{DIR_ITEM, lifeb_pkg::MODE_READ,    6'd1,  6'd1,  7'd0,   1'b0, 2'b00},
            // zero size behaves as a single cell
            '{DIR_CFG,  lifeb_pkg::MODE_READ,    6'd0,  6'd0,  7'd0,   1'b0, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_PRESS,   6'd0,  6'd1,  7'd0,   1'b1, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_READ,    6'd0,  6'd0,  7'd0,   1'b0, 2'b00},
            // oversize clamps to full board, hidden cells reappear
            '{DIR_CFG,  lifeb_pkg::MODE_READ,    6'd0,  6'd0,  7'd127, 1'b0, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_PRESS,   6'd63, 6'd62, 7'd0,   1'b0, 2'b00},
            '{DIR_ITEM, lifeb_pkg::MODE_STEP,    6'd0,  6'd0,  7'd0,   1'b1, 2'b01},
            '{DIR_ITEM, lifeb_pkg::MODE_READ,    6'd63, 6'd63, 7'd0,   1'b0, 2'b00}
        };
        foreach (shadow_board[k]) shadow_board[k] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (dir_tbl[k]) begin
            if (dir_tbl[k].kind == DIR_CFG) begin
                settle();
                set_grid_size(dir_tbl[k].size);
            end else begin
                send_item(dir_tbl[k].mode, dir_tbl[k].row, dir_tbl[k].col,
                          dir_tbl[k].checked, dir_tbl[k].want);
            end
        end

        // random part, one grid size per phase
        done = 0;
        foreach (phase_sizes[p]) begin
            settle();
            set_grid_size(phase_sizes[p]);
            for (int k = 0; k < RAND_PHASE_ITEMS; k++) begin
                idle_phase = (done * 3) / RAND_TOTAL;
                case (idle_phase)
                    0: begin
                        snd_idle_pct = 7;
                        rcv_stall_pct = 60;
                    end
                    1: begin
                        snd_idle_pct = 60;
                        rcv_stall_pct = 7;
                    end
                    default: begin
                        snd_idle_pct = 0;
                        rcv_stall_pct = 0;
                    end
                endcase
                random_sequence();
                done++;
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> life_automaton_board.f
hdl/lifeb_pkg.sv
hdl/lifeb_row_cell.sv
hdl/lifeb_row_rule.sv
hdl/life_automaton_board.sv
hdl/lifeb_checker.sv
verif/life_automaton_board_test.sv
